// ===== hdl/sgs_pkg.sv =====
// Shared types, state codes and action functions for the starter-generator supervisor.
`default_nettype none

package sgs_pkg;

    // Supervisor state codes
    localparam logic [3:0] ST_OFF       = 4'd0;
    localparam logic [3:0] ST_BOOT      = 4'd1;
    localparam logic [3:0] ST_STOPPING  = 4'd2;
    localparam logic [3:0] ST_PREEXCITE = 4'd3;
    localparam logic [3:0] ST_CRANK     = 4'd4;
    localparam logic [3:0] ST_ALT       = 4'd5;
    localparam logic [3:0] ST_STALL     = 4'd6;
    localparam logic [3:0] ST_FAULT     = 4'd7;
    localparam logic [3:0] ST_ESTOP     = 4'd8;

    // Item commands
    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    // Configuration register indexes (word address)
    localparam logic [2:0] REG_STOPPED_ERPM  = 3'd0;
    localparam logic [2:0] REG_STALL_LOW     = 3'd1;
    localparam logic [2:0] REG_STALL_RUNNING = 3'd2;
    localparam logic [2:0] REG_CRANK_TARGET  = 3'd3;
    localparam logic [2:0] REG_PRE_EXCITE    = 3'd4;
    localparam logic [2:0] REG_CRANK_TIMEOUT = 3'd5;
    localparam logic [2:0] REG_STALL_TIMEOUT = 3'd6;

    localparam logic [11:0] FIELD_FULL_MA = 12'd2500;

    typedef struct packed {
        logic [3:0]  active;
        logic [3:0]  mailbox;
        logic [31:0] time_us;
        logic        ovr_flag;
        logic [11:0] ovr_current;
        logic        enable;
        logic        gate_kill;
    } t_sgs_state;

    typedef struct packed {
        logic [15:0] stopped_erpm;
        logic [15:0] stall_low;
        logic [15:0] stall_running;
        logic [15:0] crank_target;
        logic [31:0] pre_excite_us;
        logic [31:0] crank_timeout_us;
        logic [31:0] stall_timeout_us;
    } t_sgs_cfg;

    typedef struct packed {
        logic [3:0]  state_code;
        logic        field_override;
        logic [11:0] field_current_ma;
        logic        field_enable;
        logic        stop_pwm_pulse;
        logic        zero_current_pulse;
        logic        start_speed_loop_pulse;
        logic        gate_disable;
    } t_sgs_result;

    // Transition guard: may reject (returns from), redirect or route to fault
    function automatic logic [3:0] sgs_guard(input logic [3:0] target,
                                             input logic [3:0] from,
                                             input logic       stator_off,
                                             input logic       spinning);
        logic [3:0] res;
        res = target;
        if (target == ST_PREEXCITE) begin
            if (from != ST_OFF) begin
                res = (from == ST_ALT || from == ST_STALL) ? from : ST_FAULT;
            end else if (!stator_off || spinning) begin
                res = ST_FAULT;
            end else begin
                res = ST_PREEXCITE;
            end
        end else if (target == ST_CRANK) begin
            res = (from == ST_PREEXCITE) ? ST_CRANK : ST_FAULT;
        end
        return res;
    endfunction

    // Entry action of a state on the field command flags and the gate kill flag
    function automatic t_sgs_state sgs_entry(input t_sgs_state st, input logic [3:0] s);
        t_sgs_state ns;
        ns = st;
        case (s)
            ST_OFF, ST_STOPPING, ST_FAULT: begin
                ns.ovr_flag    = 1'b1;
                ns.ovr_current = '0;
            end
            ST_BOOT: begin
                ns.enable      = 1'b1;
                ns.ovr_flag    = 1'b0;
                ns.ovr_current = '0;
            end
            ST_PREEXCITE: begin
                ns.enable      = 1'b1;
                ns.ovr_flag    = 1'b1;
                ns.ovr_current = FIELD_FULL_MA;
            end
            ST_CRANK: begin
                ns.ovr_flag    = 1'b1;
                ns.ovr_current = FIELD_FULL_MA;
            end
            ST_ALT: begin
                ns.ovr_flag = 1'b0;
            end
            ST_ESTOP: begin
                ns.gate_kill   = 1'b1;
                ns.enable      = 1'b0;
                ns.ovr_flag    = 1'b1;
                ns.ovr_current = '0;
            end
            default: begin
            end
        endcase
        return ns;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sgs_step.sv =====
// Next-state and result logic for one supervisor transaction.
`default_nettype none

module sgs_step import sgs_pkg::*; (
    input  wire t_sgs_state  i_state,
    input  wire t_sgs_cfg    i_cfg,
    input  wire              i_command,
    input  wire [3:0]        i_target_state,
    input  wire [15:0]       i_elapsed_us,
    input  wire [15:0]       i_speed_magnitude,
    input  wire              i_stator_is_off,
    input  wire              i_open_loop_active,
    input  wire              i_stator_fault,
    input  wire              i_estop_latched,
    output t_sgs_state       o_state,
    output t_sgs_result      o_result
);

    t_sgs_state  ns;
    logic [32:0] time_sum;
    logic        spinning;
    logic        crank_done;
    logic        do_resolve;
    logic        do_enter;
    logic [3:0]  enter_s;
    logic [3:0]  guard_res;
    logic [3:0]  tick_nxt;
    logic        tick_stop;

    assign spinning   = i_speed_magnitude > i_cfg.stopped_erpm;
    // 2*speed > 3*target, exact in integers
    assign crank_done = ({1'b0, i_speed_magnitude, 1'b0}) >
                        ({2'b0, i_cfg.crank_target} + {1'b0, i_cfg.crank_target, 1'b0});
    assign time_sum   = {1'b0, i_state.time_us} + {17'd0, i_elapsed_us};

    always_comb begin
        ns         = i_state;
        do_resolve = 1'b0;
        do_enter   = 1'b0;
        enter_s    = ST_OFF;
        guard_res  = ST_OFF;
        tick_nxt   = i_state.active;
        tick_stop  = 1'b0;

        if (i_command == CMD_TICK) begin
            // saturating state timer
            ns.time_us = time_sum[32] ? '1 : time_sum[31:0];
            if (i_estop_latched) begin
                ns.mailbox = ST_ESTOP;
                do_resolve = 1'b1;
            end else if (i_stator_fault && i_state.active != ST_ESTOP) begin
                ns.mailbox = ST_FAULT;
                do_resolve = 1'b1;
            end else if (i_state.active != i_state.mailbox) begin
                do_resolve = 1'b1;
            end

            if (do_resolve) begin
                // pending mailbox request
                if (i_state.active == ST_FAULT && ns.mailbox != ST_OFF &&
                    ns.mailbox != ST_ALT) begin
                    ns.mailbox = i_state.active;
                end else begin
                    guard_res = sgs_guard(ns.mailbox, i_state.active,
                                          i_stator_is_off, spinning);
                    if (guard_res == i_state.active) begin
                        ns.mailbox = i_state.active;
                    end else if (guard_res != ns.mailbox) begin
                        ns.mailbox = guard_res;
                    end else begin
                        do_enter = 1'b1;
                        enter_s  = guard_res;
                    end
                end
            end else begin
                // tick rule of the active state
                case (i_state.active)
                    ST_OFF, ST_BOOT, ST_FAULT: begin
                        if (i_state.active == ST_BOOT) begin
                            ns.enable = 1'b1;
                        end
                        if (i_state.active == ST_FAULT && i_stator_fault) begin
                            tick_nxt = ST_FAULT;
                        end else if (spinning) begin
                            ns.ovr_flag = 1'b0;
                            tick_nxt    = ST_ALT;
                        end else begin
                            tick_nxt = ST_OFF;
                        end
                    end
                    ST_STOPPING: begin
                        if (i_open_loop_active) begin
                            tick_stop = 1'b1;
                            tick_nxt  = ST_OFF;
                        end else if (i_stator_is_off) begin
                            tick_nxt = ST_OFF;
                        end
                    end
                    ST_PREEXCITE: begin
                        if (ns.time_us >= i_cfg.pre_excite_us) begin
                            tick_nxt = ST_CRANK;
                        end
                    end
                    ST_CRANK: begin
                        if (crank_done) begin
                            tick_nxt = ST_ALT;
                        end else if (ns.time_us >= i_cfg.crank_timeout_us) begin
                            tick_nxt = ST_STOPPING;
                        end
                    end
                    ST_ALT: begin
                        if (i_stator_is_off) begin
                            tick_nxt = ST_OFF;
                        end
                    end
                    ST_STALL: begin
                        if (i_speed_magnitude > i_cfg.stall_running) begin
                            tick_nxt = ST_ALT;
                        end else if (i_speed_magnitude < i_cfg.stall_low ||
                                     ns.time_us >= i_cfg.stall_timeout_us) begin
                            tick_nxt = ST_OFF;
                        end
                    end
                    default: begin
                        tick_nxt = ST_ESTOP;
                    end
                endcase
                if (tick_nxt != i_state.active) begin
                    ns.mailbox = tick_nxt;
                end
            end
        end else if (i_target_state <= ST_ESTOP && i_target_state != i_state.active &&
                     i_state.active != ST_ESTOP) begin
            // external request: guard and entry at once
            guard_res = sgs_guard(i_target_state, i_state.active, i_stator_is_off, spinning);
            if (guard_res != i_state.active) begin
                do_enter   = 1'b1;
                enter_s    = guard_res;
                ns.mailbox = guard_res;
            end
        end

        if (do_enter) begin
            ns         = sgs_entry(ns, enter_s);
            ns.active  = enter_s;
            ns.time_us = '0;
        end
    end

    assign o_state = ns;

    // Result fields
    assign o_result.state_code             = ns.active;
    assign o_result.field_override         = ns.ovr_flag;
    assign o_result.field_current_ma       = ns.ovr_current;
    assign o_result.field_enable           = ns.enable;
    assign o_result.stop_pwm_pulse         = tick_stop || (do_enter && enter_s == ST_OFF);
    assign o_result.zero_current_pulse     = do_enter && enter_s == ST_STOPPING;
    assign o_result.start_speed_loop_pulse = do_enter && enter_s == ST_CRANK;
    assign o_result.gate_disable           = ns.gate_kill;

endmodule

`default_nettype wire

// ===== hdl/starter_generator_supervisor_fsm_top.sv =====
// Top level of the starter-generator supervisor: config registers, state and output buffer.
// Results are registered; on output stall the skid register takes the next one.
// Throughput: one transaction per cycle while the skid register is empty; the state update
// is a single pass of compare logic from the state registers back into them, and a
// two-entry output buffer (result plus skid register) takes one more under output stall.
// Reset (synchronous, active low): state boot, timer and field flags cleared, buffer
// emptied, config registers to their defaults.
`default_nettype none

module starter_generator_supervisor_fsm_top import sgs_pkg::*; #(
    parameter int POLE_PAIR_CNT = 4
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // config port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [4:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  wire         i_valid,
    output logic        o_stall,
    input  wire         i_command,
    input  wire [3:0]   i_target_state,
    input  wire [15:0]  i_elapsed_us,
    input  wire [15:0]  i_speed_magnitude,
    input  wire         i_stator_is_off,
    input  wire         i_open_loop_active,
    input  wire         i_stator_fault,
    input  wire         i_estop_latched,
    // output channel
    output logic        o_valid,
    input  wire         i_stall,
    output logic [3:0]  o_current_state,
    output logic        o_field_override,
    output logic [11:0] o_field_current_ma,
    output logic        o_field_enable,
    output logic        o_stop_pwm_pulse,
    output logic        o_zero_current_pulse,
    output logic        o_start_speed_loop_pulse,
    output logic        o_gate_disable
);

    localparam logic [15:0] StoppedErpmReset = 16'(10 * POLE_PAIR_CNT);

    t_sgs_cfg    r_cfg;
    t_sgs_state  r_state;
    t_sgs_state  n_state;
    t_sgs_result n_result;
    t_sgs_result r_out;
    t_sgs_result r_skid;
    logic        r_out_valid;
    logic        r_skid_valid;
    logic        n_out_valid;
    logic        n_skid_valid;
    logic        in_acc;
    logic        out_free;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    // Config register write and read
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stopped_erpm     <= StoppedErpmReset;
            r_cfg.stall_low        <= 16'd10;
            r_cfg.stall_running    <= 16'd2400;
            r_cfg.crank_target     <= 16'd600;
            r_cfg.pre_excite_us    <= 32'd150000;
            r_cfg.crank_timeout_us <= 32'd30000000;
            r_cfg.stall_timeout_us <= 32'd1500000;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_STOPPED_ERPM:  r_cfg.stopped_erpm     <= pwdata[15:0];
                REG_STALL_LOW:     r_cfg.stall_low        <= pwdata[15:0];
                REG_STALL_RUNNING: r_cfg.stall_running    <= pwdata[15:0];
                REG_CRANK_TARGET:  r_cfg.crank_target     <= pwdata[15:0];
                REG_PRE_EXCITE:    r_cfg.pre_excite_us    <= pwdata;
                REG_CRANK_TIMEOUT: r_cfg.crank_timeout_us <= pwdata;
                REG_STALL_TIMEOUT: r_cfg.stall_timeout_us <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_STOPPED_ERPM:  prdata = {16'd0, r_cfg.stopped_erpm};
            REG_STALL_LOW:     prdata = {16'd0, r_cfg.stall_low};
            REG_STALL_RUNNING: prdata = {16'd0, r_cfg.stall_running};
            REG_CRANK_TARGET:  prdata = {16'd0, r_cfg.crank_target};
            REG_PRE_EXCITE:    prdata = r_cfg.pre_excite_us;
            REG_CRANK_TIMEOUT: prdata = r_cfg.crank_timeout_us;
            REG_STALL_TIMEOUT: prdata = r_cfg.stall_timeout_us;
            default:           prdata = '0;
        endcase
    end

    // Supervisor transaction logic
    sgs_step u_step (
        .i_state            (r_state),
        .i_cfg              (r_cfg),
        .i_command          (i_command),
        .i_target_state     (i_target_state),
        .i_elapsed_us       (i_elapsed_us),
        .i_speed_magnitude  (i_speed_magnitude),
        .i_stator_is_off    (i_stator_is_off),
        .i_open_loop_active (i_open_loop_active),
        .i_stator_fault     (i_stator_fault),
        .i_estop_latched    (i_estop_latched),
        .o_state            (n_state),
        .o_result           (n_result)
    );

    // Handshake: stall only when the skid register holds a result
    assign o_stall  = r_skid_valid;
    assign in_acc   = i_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (out_free) begin
            n_out_valid  = r_skid_valid || in_acc;
            n_skid_valid = 1'b0;
        end else if (in_acc) begin
            n_skid_valid = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.active      <= ST_BOOT;
            r_state.mailbox     <= ST_BOOT;
            r_state.time_us     <= '0;
            r_state.ovr_flag    <= 1'b0;
            r_state.ovr_current <= '0;
            r_state.enable      <= 1'b0;
            r_state.gate_kill   <= 1'b0;
            r_out_valid         <= 1'b0;
            r_skid_valid        <= 1'b0;
        end else begin
            if (in_acc) begin
                r_state <= n_state;
            end
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_acc) begin
                r_out <= n_result;
            end
        end else if (in_acc) begin
            r_skid <= n_result;
        end
    end

    assign o_valid                  = r_out_valid;
    assign o_current_state          = r_out.state_code;
    assign o_field_override         = r_out.field_override;
    assign o_field_current_ma       = r_out.field_current_ma;
    assign o_field_enable           = r_out.field_enable;
    assign o_stop_pwm_pulse         = r_out.stop_pwm_pulse;
    assign o_zero_current_pulse     = r_out.zero_current_pulse;
    assign o_start_speed_loop_pulse = r_out.start_speed_loop_pulse;
    assign o_gate_disable           = r_out.gate_disable;

endmodule

`default_nettype wire
